>>> hw/rtl/positional_list_store_assert.svh
// assertion helpers for the list store rtl
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PLS_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define PLS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/pls_pkg.sv
`default_nettype none

package pls_pkg;

   localparam int OP_W   = 3;
   localparam int POS_W  = 7;
   localparam int DATA_W = 64;
   localparam int STAT_W = 2;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_DELETE = 3'd1;
   localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
   localparam logic [OP_W-1:0] OP_READ   = 3'd3;
   localparam logic [OP_W-1:0] OP_WRITE  = 3'd4;
   localparam logic [OP_W-1:0] OP_CURSOR = 3'd5;

   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_SHIFT_DOWN,
      S_DRAIN,
      S_PLACE,
      S_SCAN,
      S_FETCH,
      S_LOAD,
      S_REPLY
   } state_type;

   // write port control for the element store
   typedef struct packed {
      logic we;
      logic from_rd;
   } store_ctrl_type;

endpackage

`default_nettype wire

>>> hw/rtl/pls_store.sv
`default_nettype none

module pls_store #(
   parameter int DEPTH = 64,
   parameter int AW    = 6
) (
   input  wire logic                       clock,
   input  wire pls_pkg::store_ctrl_type    ctrl,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [pls_pkg::DATA_W-1:0] wr_value,
   input  wire logic [AW-1:0]              rd_addr,
   output logic [pls_pkg::DATA_W-1:0]      rd_data
);

   logic [pls_pkg::DATA_W-1:0] store_ff [DEPTH];
   logic [pls_pkg::DATA_W-1:0] rd_data_ff;
   logic [pls_pkg::DATA_W-1:0] wr_data_in;

   // a shift step writes back the word read in the previous cycle
   assign wr_data_in = ctrl.from_rd ? rd_data_ff : wr_value;

   always_ff @(posedge clock) begin
      if (ctrl.we) begin
         store_ff[wr_addr] <= wr_data_in;
      end
      rd_data_ff <= store_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> hw/rtl/positional_list_store.sv
// positional_list_store: bounded ordered list of 64-bit words in a compacted
// single-port-write, single-port-read memory, with an element count and a cursor.
// usage: drive req_operation, req_position and req_value with start high; the
// request is taken on a clock edge where busy is low. busy then stays high until
// the result has been shown. one result per request: rsp_valid is high for exactly
// one cycle with all rsp_ fields; the receiver cannot stall, so it must take it.
// steps from the accepting edge to the strobe, one memory word per cycle:
//   insert: shift up the entries from the position on, drain, place, reply,
//           or only place and reply when the word goes at the tail
//   delete: shift down the later entries, drain, reply, or only reply at the tail
//   search: scan up to a hit or the last entry, then reply; only reply when empty
//   read: fetch, load, reply; write: place, reply; cursor, rejected, unused: reply
// the next request is taken in the cycle after the strobe. the single memory
// read and write port and the one 64-bit equality compare set the pace of the
// shifts and the scan.
// reset clears the count and the cursor; the memory is not cleared and only
// entries below the count are ever used.
`default_nettype none
`include "positional_list_store_assert.svh"

module positional_list_store #(
   parameter int CAPACITY = 64
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  wire logic [pls_pkg::OP_W-1:0]    req_operation,
   input  wire logic [pls_pkg::POS_W-1:0]   req_position,
   input  wire logic [pls_pkg::DATA_W-1:0]  req_value,
   output logic                             rsp_valid,
   output logic [pls_pkg::STAT_W-1:0]       rsp_status,
   output logic [pls_pkg::POS_W-1:0]        rsp_found_position,
   output logic [pls_pkg::DATA_W-1:0]       rsp_read_data,
   output logic [pls_pkg::POS_W-1:0]        rsp_element_count,
   output logic                             rsp_empty_flag,
   output logic [pls_pkg::POS_W-1:0]        rsp_cursor_position,
   output logic [pls_pkg::POS_W-1:0]        rsp_next_position
);

   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int XW = (CW > pls_pkg::POS_W) ? CW : pls_pkg::POS_W;

   pls_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 count_ff, count_in;
   logic [pls_pkg::POS_W-1:0]     cursor_ff, cursor_in;
   logic [pls_pkg::OP_W-1:0]      op_ff, op_in;
   logic [pls_pkg::DATA_W-1:0]    val_ff, val_in;
   logic [AW-1:0]                 ptr_ff, ptr_in;
   logic [AW-1:0]                 last_ff, last_in;
   logic [AW-1:0]                 place_ff, place_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 wa_ff, wa_in;
   logic                          cmp_vld_ff, cmp_vld_in;
   logic [AW-1:0]                 cmp_idx_ff, cmp_idx_in;
   logic [pls_pkg::STAT_W-1:0]    status_ff, status_in;
   logic [pls_pkg::POS_W-1:0]     found_ff, found_in;
   logic [pls_pkg::DATA_W-1:0]    rdata_ff, rdata_in;

   logic [XW-1:0]                 p_x, n_x, c_x;
   logic                          accept;
   logic                          hit;
   logic [pls_pkg::DATA_W-1:0]    rd_data;
   logic [AW-1:0]                 wr_addr;
   pls_pkg::store_ctrl_type       store_ctrl;

   assign p_x    = XW'(req_position);
   assign n_x    = XW'(count_ff);
   assign c_x    = XW'(cursor_ff);
   assign accept = start && !busy;

   // single equality compare, used by the scan, against the word read last cycle
   assign hit = (rd_data == val_ff);

   pls_store #(
      .DEPTH (CAPACITY),
      .AW    (AW)
   ) u_store (
      .clock    (clock),
      .ctrl     (store_ctrl),
      .wr_addr  (wr_addr),
      .wr_value (val_ff),
      .rd_addr  (ptr_ff),
      .rd_data  (rd_data)
   );

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      cursor_in  = cursor_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      ptr_in     = ptr_ff;
      last_in    = last_ff;
      place_in   = place_ff;
      pend_in    = 1'b0;
      wa_in      = wa_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      status_in  = status_ff;
      found_in   = found_ff;
      rdata_in   = rdata_ff;

      store_ctrl.we      = pend_ff || (state_ff == pls_pkg::S_PLACE);
      store_ctrl.from_rd = pend_ff;
      wr_addr            = pend_ff ? wa_ff : place_ff;

      unique case (state_ff)
         pls_pkg::S_IDLE: begin
            if (accept) begin
               op_in     = req_operation;
               val_in    = req_value;
               status_in = pls_pkg::STAT_OK;
               found_in  = '0;
               rdata_in  = '0;
               state_in  = pls_pkg::S_REPLY;
               unique case (req_operation)
                  pls_pkg::OP_INSERT: begin
                     if (p_x > n_x) begin
                        status_in = pls_pkg::STAT_RANGE;
                     end else if (count_ff == CW'(CAPACITY)) begin
                        status_in = pls_pkg::STAT_FULL;
                     end else begin
                        count_in = count_ff + CW'(1);
                        place_in = AW'(p_x);
                        if (p_x == n_x) begin
                           state_in = pls_pkg::S_PLACE;
                        end else begin
                           ptr_in   = AW'(count_ff - CW'(1));
                           last_in  = AW'(p_x);
                           state_in = pls_pkg::S_SHIFT_UP;
                        end
                     end
                  end
                  pls_pkg::OP_DELETE: begin
                     if (p_x == '0 || p_x > n_x) begin
                        status_in = pls_pkg::STAT_RANGE;
                     end else begin
                        count_in = count_ff - CW'(1);
                        if (p_x != n_x) begin
                           ptr_in   = AW'(p_x);
                           last_in  = AW'(count_ff - CW'(1));
                           state_in = pls_pkg::S_SHIFT_DOWN;
                        end
                     end
                  end
                  pls_pkg::OP_SEARCH: begin
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        last_in  = AW'(count_ff - CW'(1));
                        state_in = pls_pkg::S_SCAN;
                     end
                  end
                  pls_pkg::OP_READ: begin
                     if (p_x == '0 || p_x > n_x) begin
                        status_in = pls_pkg::STAT_RANGE;
                     end else begin
                        ptr_in   = AW'(p_x - XW'(1));
                        state_in = pls_pkg::S_FETCH;
                     end
                  end
                  pls_pkg::OP_WRITE: begin
                     if (p_x == '0 || p_x > n_x) begin
                        status_in = pls_pkg::STAT_RANGE;
                     end else begin
                        place_in = AW'(p_x - XW'(1));
                        state_in = pls_pkg::S_PLACE;
                     end
                  end
                  pls_pkg::OP_CURSOR: begin
                     if (p_x > n_x) begin
                        status_in = pls_pkg::STAT_RANGE;
                     end else begin
                        cursor_in = req_position;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pls_pkg::S_SHIFT_UP: begin
            // word read at ptr lands at ptr + 1 next cycle
            pend_in = 1'b1;
            wa_in   = ptr_ff + AW'(1);
            if (ptr_ff == last_ff) begin
               state_in = pls_pkg::S_DRAIN;
            end else begin
               ptr_in = ptr_ff - AW'(1);
            end
         end
         pls_pkg::S_SHIFT_DOWN: begin
            pend_in = 1'b1;
            wa_in   = ptr_ff - AW'(1);
            if (ptr_ff == last_ff) begin
               state_in = pls_pkg::S_DRAIN;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         pls_pkg::S_DRAIN: begin
            state_in = (op_ff == pls_pkg::OP_INSERT) ? pls_pkg::S_PLACE : pls_pkg::S_REPLY;
         end
         pls_pkg::S_PLACE: begin
            state_in = pls_pkg::S_REPLY;
         end
         pls_pkg::S_SCAN: begin
            // reads run one ahead of the compare
            ptr_in     = ptr_ff + AW'(1);
            cmp_vld_in = 1'b1;
            cmp_idx_in = ptr_ff;
            if (cmp_vld_ff && hit) begin
               found_in   = pls_pkg::POS_W'(CW'(cmp_idx_ff) + CW'(1));
               cmp_vld_in = 1'b0;
               state_in   = pls_pkg::S_REPLY;
            end else if (cmp_vld_ff && cmp_idx_ff == last_ff) begin
               cmp_vld_in = 1'b0;
               state_in   = pls_pkg::S_REPLY;
            end
         end
         pls_pkg::S_FETCH: begin
            state_in = pls_pkg::S_LOAD;
         end
         pls_pkg::S_LOAD: begin
            rdata_in = rd_data;
            state_in = pls_pkg::S_REPLY;
         end
         pls_pkg::S_REPLY: begin
            state_in = pls_pkg::S_IDLE;
         end
         default: begin
            state_in = pls_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= pls_pkg::S_IDLE;
         count_ff   <= '0;
         cursor_ff  <= '0;
         pend_ff    <= 1'b0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cursor_ff  <= cursor_in;
         pend_ff    <= pend_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      ptr_ff     <= ptr_in;
      last_ff    <= last_in;
      place_ff   <= place_in;
      wa_ff      <= wa_in;
      cmp_idx_ff <= cmp_idx_in;
      status_ff  <= status_in;
      found_ff   <= found_in;
      rdata_ff   <= rdata_in;
   end

   assign busy                = (state_ff != pls_pkg::S_IDLE);
   assign rsp_valid           = (state_ff == pls_pkg::S_REPLY);
   assign rsp_status          = status_ff;
   assign rsp_found_position  = found_ff;
   assign rsp_read_data       = rdata_ff;
   assign rsp_element_count   = pls_pkg::POS_W'(count_ff);
   assign rsp_empty_flag      = (count_ff == '0);
   assign rsp_cursor_position = cursor_ff;
   assign rsp_next_position   = (c_x >= n_x) ? '0 : pls_pkg::POS_W'(c_x + XW'(1));

   `PLS_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
   `PLS_ASSERT_NEXT(a_strobe_release, rsp_valid, !busy && !rsp_valid, "result strobe not single")
   `PLS_ASSERT_NEXT(a_insert_count,
      accept && req_operation == pls_pkg::OP_INSERT && p_x <= n_x && count_ff != CW'(CAPACITY),
      count_ff == $past(count_ff) + CW'(1), "insert did not grow the count")
   `PLS_ASSERT_IMPLY(a_found_bound, rsp_valid && rsp_found_position != '0,
      XW'(rsp_found_position) <= n_x, "search hit beyond the count")
   `PLS_ASSERT_IMPLY(a_write_idle, store_ctrl.we, busy, "memory written while idle")

endmodule

`default_nettype wire
